### design/mtab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtab_pkg
// Shared constants for the MAC keyed device table: request modes, status
// codes, field widths and the default table depth.
// ----------------------------------------------------------------------------
package mtab_pkg;

    localparam int MTAB_ENTRIES = 16;

    localparam int MODE_W  = 3;
    localparam int MAC_W   = 48;
    localparam int TAG_W   = 8;
    localparam int STAT_W  = 2;
    localparam int CNTO_W  = 5;
    localparam int REC_W   = MAC_W + TAG_W;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 64;

    // request modes
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIND_MAC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIND_TAG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd5;

    // result status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

### design/mac_keyed_device_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_keyed_device_table
// Table of device records (48-bit MAC, 8-bit id) with insert/update, find by
// MAC, find by id (newest wins), delete, count and clear requests.
// ----------------------------------------------------------------------------
// One request is taken at a time. Records sit in a single-port-read memory,
// oldest at address 0, packed with no gaps; a record count replaces per-entry
// valid bits. Count, clear and unknown modes, and requests on an empty table,
// go straight to the result register. Insert, finds and delete otherwise scan
// the table newest-first through one registered memory read and one
// comparator, one record a cycle; a delete then closes the gap one record a
// cycle. The input is accepted again once the result has been moved to the
// output register, which holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
module mac_keyed_device_table
    import mtab_pkg::*;
#(
    parameter int ENTRIES = MTAB_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // mode[2:0], mac_key[50:3], device_tag[58:51], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status[1:0], found_mac[49:2], found_tag[57:50], entry_count[62:58], zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        SHIFT,
        RESP
    } state_t;

    state_t              state_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [MAC_W-1:0]    key_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [IW-1:0]       ptr_reg;
    logic [CW-1:0]       count_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic [MAC_W-1:0]    res_mac_reg;
    logic [TAG_W-1:0]    res_tag_reg;
    logic                m_tvalid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [MAC_W-1:0]    out_mac_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [CNTO_W-1:0]   out_count_reg;

    logic [REC_W-1:0]    mem [ENTRIES];
    logic [REC_W-1:0]    rd_data_reg;

    logic [MODE_W-1:0]   in_mode;
    logic [MAC_W-1:0]    in_mac;
    logic [TAG_W-1:0]    in_tag;
    logic                accept;
    logic [MAC_W-1:0]    rd_mac;
    logic [TAG_W-1:0]    rd_tag;
    logic                hit;
    logic [CW-1:0]       ptr_ext;
    logic                ptr_last;
    logic                shift_last;
    logic                full;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [REC_W-1:0]    wr_data;
    logic [CW+CNTO_W-1:0] count_ext;
    logic                out_load;

    assign in_mode = s_axis_tdata[MODE_W-1:0];
    assign in_mac  = s_axis_tdata[MODE_W+MAC_W-1:MODE_W];
    assign in_tag  = s_axis_tdata[MODE_W+MAC_W+TAG_W-1:MODE_W+MAC_W];

    assign s_axis_tready = (state_reg == IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rd_mac = rd_data_reg[REC_W-1:TAG_W];
    assign rd_tag = rd_data_reg[TAG_W-1:0];
    assign hit    = (mode_reg == MODE_FIND_TAG) ? (rd_tag == tag_reg) : (rd_mac == key_reg);

    assign ptr_ext    = CW'(ptr_reg);
    assign ptr_last   = ((ptr_ext + CW'(1)) == count_reg);
    assign shift_last = ((ptr_ext + CW'(2)) == count_reg);
    assign full       = (count_reg == CW'(ENTRIES));
    assign count_ext  = {{CNTO_W{1'b0}}, count_reg};

    // load the output register once it is free or being emptied
    assign out_load = (state_reg == RESP) && (!m_tvalid_reg || m_axis_tready);

    // memory addressing: the read runs one record ahead of the compare
    always_comb
    begin
        rd_addr = ptr_reg;
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            IDLE:
            begin
                rd_addr = IW'(count_reg - CW'(1));
                if (accept && (in_mode == MODE_INSERT) && (count_reg == '0))
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = {in_mac, in_tag};
                end
            end
            SCAN:
            begin
                if (hit)
                begin
                    rd_addr = IW'(ptr_ext + CW'(1));
                    if (mode_reg == MODE_INSERT)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ptr_reg;
                        wr_data = {key_reg, tag_reg};
                    end
                end
                else
                begin
                    rd_addr = IW'(ptr_ext - CW'(1));
                    if ((ptr_reg == '0) && (mode_reg == MODE_INSERT) && !full)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IW'(count_reg);
                        wr_data = {key_reg, tag_reg};
                    end
                end
            end
            SHIFT:
            begin
                // move the record above down into the gap
                rd_addr = IW'(ptr_ext + CW'(2));
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
            end
            RESP:
            begin
                rd_addr = ptr_reg;
            end
            default:
            begin
                rd_addr = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            mode_reg       <= MODE_COUNT;
            key_reg        <= '0;
            tag_reg        <= '0;
            ptr_reg        <= '0;
            res_status_reg <= ST_OK;
            res_mac_reg    <= '0;
            res_tag_reg    <= '0;
            out_status_reg <= ST_OK;
            out_mac_reg    <= '0;
            out_tag_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg       <= in_mode;
                        key_reg        <= in_mac;
                        tag_reg        <= in_tag;
                        ptr_reg        <= IW'(count_reg - CW'(1));
                        res_mac_reg    <= '0;
                        res_tag_reg    <= '0;
                        res_status_reg <= ST_MISS;
                        state_reg      <= RESP;
                        unique case (in_mode)
                            MODE_INSERT:
                            begin
                                if (count_reg == '0)
                                begin
                                    count_reg      <= CW'(1);
                                    res_status_reg <= ST_OK;
                                    res_mac_reg    <= in_mac;
                                    res_tag_reg    <= in_tag;
                                end
                                else
                                begin
                                    state_reg <= SCAN;
                                end
                            end
                            MODE_FIND_MAC, MODE_FIND_TAG, MODE_DELETE:
                            begin
                                if (count_reg != '0)
                                begin
                                    state_reg <= SCAN;
                                end
                            end
                            MODE_COUNT:
                            begin
                                res_status_reg <= ST_OK;
                            end
                            MODE_CLEAR:
                            begin
                                count_reg      <= '0;
                                res_status_reg <= ST_OK;
                            end
                            default:
                            begin
                                res_status_reg <= ST_MISS;
                            end
                        endcase
                    end
                end
                SCAN:
                begin
                    if (hit)
                    begin
                        res_status_reg <= ST_OK;
                        res_mac_reg    <= rd_mac;
                        res_tag_reg    <= (mode_reg == MODE_INSERT) ? tag_reg : rd_tag;
                        state_reg      <= RESP;
                        if (mode_reg == MODE_DELETE)
                        begin
                            if (ptr_last)
                            begin
                                count_reg <= count_reg - CW'(1);
                            end
                            else
                            begin
                                state_reg <= SHIFT;
                            end
                        end
                    end
                    else if (ptr_reg == '0)
                    begin
                        state_reg <= RESP;
                        if (mode_reg == MODE_INSERT)
                        begin
                            if (full)
                            begin
                                res_status_reg <= ST_FULL;
                            end
                            else
                            begin
                                count_reg      <= count_reg + CW'(1);
                                res_status_reg <= ST_OK;
                                res_mac_reg    <= key_reg;
                                res_tag_reg    <= tag_reg;
                            end
                        end
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg - IW'(1);
                    end
                end
                SHIFT:
                begin
                    if (shift_last)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= RESP;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + IW'(1);
                    end
                end
                RESP:
                begin
                    // hold until the output register is free
                    if (out_load)
                    begin
                        out_status_reg <= res_status_reg;
                        out_mac_reg    <= res_mac_reg;
                        out_tag_reg    <= res_tag_reg;
                        out_count_reg  <= count_ext[CNTO_W-1:0];
                        state_reg      <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - STAT_W - MAC_W - TAG_W - CNTO_W){1'b0}},
                            out_count_reg, out_tag_reg, out_mac_reg, out_status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("record count above table depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("second request taken while one is in progress");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_mode == MODE_CLEAR) |=> (count_reg == '0))
        else $error("clear left records in the table");

    a_full_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (out_status_reg == ST_FULL) |->
            (out_mac_reg == '0) && (out_tag_reg == '0))
        else $error("full status carries a record");

endmodule
